### rtl/core/est_pkg.sv
// Shared constants, codes and types of the element set table.
package est_pkg;

	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 6;
	localparam int TOTAL_W  = 7;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_SEARCH = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_DUPLICATE = 2'd1,
		ST_ABSENT    = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]         status;
		logic               found;
		logic [POS_W-1:0]   position;
		logic [TOTAL_W-1:0] element_total;
		logic               is_empty;
		logic               is_full;
	} rsp_t;

endpackage

### rtl/core/est_if.sv
// Request and response channel interfaces of the element set table.
interface est_req_if import est_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [1:0]                action;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, action, value, input ready);
	modport sink (input valid, action, value, output ready);
endinterface

interface est_rsp_if import est_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic               found;
	logic [POS_W-1:0]   position;
	logic [TOTAL_W-1:0] element_total;
	logic               is_empty;
	logic               is_full;

	modport source (output valid, status, found, position, element_total, is_empty, is_full,
		input ready);
	modport sink (input valid, status, found, position, element_total, is_empty, is_full,
		output ready);
endinterface

### rtl/core/element_set_table_core.sv
// Top level of the element set table: store, sequencer and response register.
//
// The block keeps a set of up to CAPACITY distinct signed 32-bit words.
// Each transaction on the request channel carries an action (insert,
// remove or search) and a value; each one yields exactly one transaction
// on the response channel with a status code, a found flag, the matching
// position, the element count after the operation and empty and full flags.
// Requests are handled one at a time. A request is taken only while the
// sequencer is idle; a search or an insert then reads the stored entries
// in order through the store's single registered read port until a match
// or the last entry and then replies, and a remove that hits scans up to
// the match and then moves the tail behind it, reading each later entry
// and writing it back one place lower. The response is held in an output
// register, so the next request may be taken while an earlier response
// still waits. When the receiver stalls, a finished result waits in the
// sequencer until the output register frees. Reset empties the set at
// once (only the count is cleared; the store needs no clearing) and drops
// any response not yet delivered.
module element_set_table_core import est_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	est_req_if.sink    req,
	est_rsp_if.source  rsp
);

	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [VALUE_W-1:0] ram_wdata;
	logic               ram_re;
	logic [ADDR_W-1:0]  ram_raddr;
	logic [VALUE_W-1:0] ram_rdata;

	logic res_free;
	logic res_valid;
	rsp_t res;

	logic rsp_valid_q;
	rsp_t rsp_q;

	// The element store: one write and one read per cycle.
	est_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(VALUE_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	est_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata),
		.res_free (res_free),
		.res_valid(res_valid),
		.res      (res)
	);

	// The output register may take a new result when it is empty or is
	// being emptied in this cycle.
	assign res_free = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = rsp_q.status;
	assign rsp.found         = rsp_q.found;
	assign rsp.position      = rsp_q.position;
	assign rsp.element_total = rsp_q.element_total;
	assign rsp.is_empty      = rsp_q.is_empty;
	assign rsp.is_full       = rsp_q.is_full;

endmodule

### rtl/core/est_ram.sv
// Simple dual-port synchronous RAM with one write port and a registered read port.
module est_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/core/est_ctrl.sv
// Sequencer that scans, appends to and compacts the element store.
module est_ctrl import est_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	est_req_if.sink            req,
	output logic               ram_we,
	output logic [ADDR_W-1:0]  ram_waddr,
	output logic [VALUE_W-1:0] ram_wdata,
	output logic               ram_re,
	output logic [ADDR_W-1:0]  ram_raddr,
	input  logic [VALUE_W-1:0] ram_rdata,
	input  logic               res_free,
	output logic               res_valid,
	output rsp_t               res
);

	typedef enum logic [1:0] {
		IDLE,
		SCAN,
		SHIFT,
		REPLY
	} state_t;

	state_t             state_q;
	logic [1:0]         act_q;
	logic [VALUE_W-1:0] value_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   idx_q;
	logic               rd_vld_s1;
	logic [ADDR_W-1:0]  rd_idx_s1;
	status_t            status_q;
	logic               found_q;
	logic [POS_W-1:0]   pos_q;

	logic             match;
	logic             last_rd;
	logic             scan_done;
	logic             is_full_now;
	logic             issue;
	logic [CNT_W-1:0] next_idx;

	assign req.ready   = (state_q == IDLE);
	assign match       = rd_vld_s1 && (ram_rdata == value_q);
	assign last_rd     = rd_vld_s1 && (CNT_W'(rd_idx_s1) == count_q - CNT_W'(1));
	assign scan_done   = match || (count_q == '0) || last_rd;
	assign is_full_now = (count_q == CNT_W'(CAPACITY));
	assign issue       = ((state_q == SCAN) || (state_q == SHIFT)) && (idx_q != count_q);
	assign next_idx    = CNT_W'(rd_idx_s1) + CNT_W'(1);

	assign ram_re    = issue;
	assign ram_raddr = idx_q[ADDR_W-1:0];

	// Write port: append on a successful insert, or move an entry down during compaction.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[ADDR_W-1:0];
		ram_wdata = value_q;
		if ((state_q == SCAN) && scan_done && !match && (act_q == ACT_INSERT) &&
			!is_full_now) begin
			ram_we = 1'b1;
		end else if ((state_q == SHIFT) && rd_vld_s1) begin
			ram_we    = 1'b1;
			ram_waddr = rd_idx_s1 - ADDR_W'(1);
			ram_wdata = ram_rdata;
		end
	end

	assign res_valid         = (state_q == REPLY) && res_free;
	assign res.status        = status_q;
	assign res.found         = found_q;
	assign res.position      = pos_q;
	assign res.element_total = TOTAL_W'(count_q);
	assign res.is_empty      = (count_q == '0);
	assign res.is_full       = is_full_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			count_q   <= '0;
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= '0;
			act_q     <= '0;
			value_q   <= '0;
			status_q  <= ST_DONE;
			found_q   <= 1'b0;
			pos_q     <= '0;
		end else begin
			unique case (state_q)
				IDLE: begin
					rd_vld_s1 <= 1'b0;
					if (req.valid) begin
						act_q   <= req.action;
						value_q <= req.value;
						idx_q   <= '0;
						state_q <= SCAN;
					end
				end
				SCAN: begin
					rd_vld_s1 <= issue;
					rd_idx_s1 <= idx_q[ADDR_W-1:0];
					if (issue) begin
						idx_q <= idx_q + CNT_W'(1);
					end
					if (scan_done) begin
						rd_vld_s1 <= 1'b0;
						found_q   <= match;
						pos_q     <= match ? POS_W'(rd_idx_s1) : '0;
						state_q   <= REPLY;
						case (act_q)
							ACT_INSERT: begin
								if (match) begin
									status_q <= ST_DUPLICATE;
								end else if (is_full_now) begin
									status_q <= ST_FULL;
								end else begin
									status_q <= ST_DONE;
									count_q  <= count_q + CNT_W'(1);
								end
							end
							ACT_REMOVE: begin
								if (match) begin
									status_q <= ST_DONE;
									if (next_idx == count_q) begin
										count_q <= count_q - CNT_W'(1);
									end else begin
										idx_q   <= next_idx;
										state_q <= SHIFT;
									end
								end else begin
									status_q <= ST_ABSENT;
								end
							end
							default: begin
								status_q <= match ? ST_DONE : ST_ABSENT;
							end
						endcase
					end
				end
				SHIFT: begin
					rd_vld_s1 <= issue;
					rd_idx_s1 <= idx_q[ADDR_W-1:0];
					if (issue) begin
						idx_q <= idx_q + CNT_W'(1);
					end
					if (last_rd) begin
						rd_vld_s1 <= 1'b0;
						count_q   <= count_q - CNT_W'(1);
						state_q   <= REPLY;
					end
				end
				REPLY: begin
					if (res_free) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule
